// ===== rtl/glzw_pkg.sv =====
// shared types, constants and helpers for the gif lzw encoder
// no dependencies; used by gif_lzw_encoder_unit
`default_nettype none

package glzw_pkg;

  localparam int TABLE_DEPTH   = 4096;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int LINK_W        = ADDR_W + 1;
  localparam int ROOT_COUNT    = 256;
  localparam int COLOR_W       = 8;
  localparam int BUF_W         = 32;
  localparam int CNT_W         = 6;
  localparam int SIZE_W        = 4;

  localparam logic [LINK_W-1:0] NO_LINK        = '1;
  localparam logic [LINK_W-1:0] LAST_FREE_CODE = LINK_W'(4093);
  localparam logic [SIZE_W-1:0] MAX_CODE_BITS  = SIZE_W'(12);
  localparam logic [SIZE_W-1:0] MIN_SIZE_LO    = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] MIN_SIZE_HI    = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] MIN_SIZE_RESET = SIZE_W'(8);

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHILD,
    ST_WALK,
    ST_EMIT,
    ST_CLEAR,
    ST_FIN_END,
    ST_DRAIN
  } state_t;

  // sibling link and color of one table node, kept in one word
  typedef struct packed {
    logic [LINK_W-1:0]  sibling;
    logic [COLOR_W-1:0] color;
  } node_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s < MIN_SIZE_LO) r = MIN_SIZE_LO;
    if (s > MIN_SIZE_HI) r = MIN_SIZE_HI;
    return r;
  endfunction

  function automatic logic [COLOR_W:0] colors_of(input logic [SIZE_W-1:0] s);
    return (COLOR_W+1)'(1) << s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/glzw_in_if.sv =====
// input channel of the gif lzw encoder: item kind and pixel index
// depends on nothing but the valid/ready handshake
`default_nettype none

interface glzw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] pixel;

  modport source (output valid, kind, pixel, input ready);
  modport sink   (input valid, kind, pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/glzw_out_if.sv =====
// output channel of the gif lzw encoder: one packed code byte per transaction
// depends on nothing but the valid/ready handshake
`default_nettype none

interface glzw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_stream;

  modport source (output valid, out_byte, last_of_run, end_of_stream, input ready);
  modport sink   (input valid, out_byte, last_of_run, end_of_stream, output ready);
endinterface

`default_nettype wire

// ===== rtl/gif_lzw_encoder_unit.sv =====
// gif lzw encoder: trie in two table memories, lsb-first code packing
// depends on glzw_pkg, glzw_in_if and glzw_out_if
//
// channel   dir  payload                                   transaction
// in_ch     in   kind[1:0], pixel[7:0]                     valid & ready
// out_ch    out  out_byte[7:0], last_of_run, end_of_stream valid & ready
// cfg       in   cfg_wdata[3:0] (min_code_size)            cfg_we
//
// one item at a time; in_ch.ready is high only between items
// pixel: the first of a stream only sets the prefix; others read the child link, walk
//   the siblings (one node read per cycle) and stop if they extend a string, else the
//   prefix code goes out and a new code is added (plus a clear code on a table clear)
// finish: pending and end codes go out, all bits drain; start, unused kinds: idle only
// reset is synchronous and needs no clearing pass: root child links use valid bits
// a stalled out_ch holds the byte and the block until it is taken
`default_nettype none

module gif_lzw_encoder_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  glzw_in_if.sink         in_ch,
  glzw_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata
);

  localparam int AW = glzw_pkg::ADDR_W;
  localparam int LW = glzw_pkg::LINK_W;
  localparam int CW = glzw_pkg::COLOR_W;
  localparam int BW = glzw_pkg::BUF_W;
  localparam int NW = glzw_pkg::CNT_W;
  localparam int SW = glzw_pkg::SIZE_W;
  localparam int RW = $clog2(glzw_pkg::ROOT_COUNT);

  // table memories
  logic [LW-1:0]        child_mem [glzw_pkg::TABLE_DEPTH];
  glzw_pkg::node_t      node_mem  [glzw_pkg::TABLE_DEPTH];
  logic [LW-1:0]        child_rd;
  glzw_pkg::node_t      node_rd;
  logic                 child_we, node_we;
  logic [AW-1:0]        child_wa, node_wa, child_ra, node_ra;
  logic [LW-1:0]        child_wd;
  glzw_pkg::node_t      node_wd;

  // registers
  glzw_pkg::state_t     state, state_next;
  logic [SW-1:0]        min_code_size;
  logic [SW-1:0]        size_now, size_now_next;
  logic [SW-1:0]        code_width, code_width_next;
  logic [LW-1:0]        nfc, nfc_next;
  logic [BW-1:0]        bit_buf, bit_buf_next;
  logic [NW-1:0]        bit_count, bit_count_next;
  logic [AW-1:0]        prefix, prefix_next;
  logic                 awaiting, awaiting_next;
  logic                 flush_all, flush_all_next;
  logic [glzw_pkg::ROOT_COUNT-1:0] root_valid, root_valid_next;
  logic [CW-1:0]        pix, pix_next;
  logic [AW-1:0]        cur, cur_next;
  logic                 root_nolink;

  // datapath helpers
  logic [CW:0]          colors;
  logic [CW:0]          colors_m1;
  logic [CW-1:0]        pix_in;
  logic [LW-1:0]        child_eff;
  logic                 grow;
  logic                 have_byte;
  logic                 out_fire;
  logic                 put_en;
  logic [AW-1:0]        put_val;
  logic                 do_init;
  logic                 clear_roots;
  logic [SW-1:0]        init_size;
  logic [CW:0]          init_colors;

  assign colors      = glzw_pkg::colors_of(size_now);
  assign colors_m1   = colors - (CW+1)'(1);
  assign pix_in      = in_ch.pixel & colors_m1[CW-1:0];
  assign child_eff   = root_nolink ? glzw_pkg::NO_LINK : child_rd;
  assign grow        = ((nfc >> code_width) != '0) || (nfc == glzw_pkg::LAST_FREE_CODE);
  assign have_byte   = (bit_count >= NW'(8)) || (flush_all && (bit_count != '0));
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign init_size   = glzw_pkg::eff_size(min_code_size);
  assign init_colors = glzw_pkg::colors_of(init_size);

  assign in_ch.ready          = (state == glzw_pkg::ST_IDLE);
  assign out_ch.valid         = (state == glzw_pkg::ST_DRAIN) && have_byte;
  assign out_ch.out_byte      = bit_buf[7:0];
  assign out_ch.last_of_run   = flush_all ? (bit_count <= NW'(8)) : (bit_count < NW'(16));
  assign out_ch.end_of_stream = flush_all && (bit_count <= NW'(8));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      glzw_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.kind)
            glzw_pkg::KIND_PIXEL:  state_next = awaiting ? glzw_pkg::ST_IDLE
                                                         : glzw_pkg::ST_CHILD;
            glzw_pkg::KIND_FINISH: state_next = glzw_pkg::ST_FIN_END;
            default:               state_next = glzw_pkg::ST_IDLE;
          endcase
        end
      end
      glzw_pkg::ST_CHILD: begin
        state_next = (child_eff == glzw_pkg::NO_LINK) ? glzw_pkg::ST_EMIT
                                                      : glzw_pkg::ST_WALK;
      end
      glzw_pkg::ST_WALK: begin
        if (node_rd.color == pix) begin
          state_next = glzw_pkg::ST_IDLE;
        end else if (node_rd.sibling == glzw_pkg::NO_LINK) begin
          state_next = glzw_pkg::ST_EMIT;
        end
      end
      glzw_pkg::ST_EMIT: begin
        state_next = (grow && code_width >= glzw_pkg::MAX_CODE_BITS) ? glzw_pkg::ST_CLEAR
                                                                     : glzw_pkg::ST_DRAIN;
      end
      glzw_pkg::ST_CLEAR:   state_next = glzw_pkg::ST_DRAIN;
      glzw_pkg::ST_FIN_END: state_next = glzw_pkg::ST_DRAIN;
      glzw_pkg::ST_DRAIN: begin
        if (!have_byte) state_next = glzw_pkg::ST_IDLE;
      end
      default: state_next = glzw_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    size_now_next   = size_now;
    code_width_next = code_width;
    nfc_next        = nfc;
    bit_buf_next    = bit_buf;
    bit_count_next  = bit_count;
    prefix_next     = prefix;
    awaiting_next   = awaiting;
    flush_all_next  = flush_all;
    root_valid_next = root_valid;
    pix_next        = pix;
    cur_next        = cur;
    child_we        = 1'b0;
    child_wa        = prefix;
    child_wd        = nfc;
    child_ra        = prefix;
    node_we         = 1'b0;
    node_wa         = cur;
    node_wd         = node_rd;
    node_ra         = cur;
    put_en          = 1'b0;
    put_val         = prefix;
    do_init         = 1'b0;
    clear_roots     = 1'b0;

    unique case (state)
      glzw_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.kind)
            glzw_pkg::KIND_PIXEL: begin
              if (awaiting) begin
                prefix_next   = AW'(pix_in);
                awaiting_next = 1'b0;
              end else begin
                pix_next = pix_in;
              end
            end
            glzw_pkg::KIND_FINISH: begin
              put_en         = !awaiting;
              flush_all_next = 1'b1;
            end
            glzw_pkg::KIND_START: do_init = 1'b1;
            default: ;
          endcase
        end
      end
      glzw_pkg::ST_CHILD: begin
        if (child_eff == glzw_pkg::NO_LINK) begin
          child_we = 1'b1;
        end else begin
          cur_next = child_eff[AW-1:0];
          node_ra  = child_eff[AW-1:0];
        end
      end
      glzw_pkg::ST_WALK: begin
        if (node_rd.color == pix) begin
          prefix_next = cur;
        end else if (node_rd.sibling == glzw_pkg::NO_LINK) begin
          // append the new code at the tail of the sibling list
          node_we         = 1'b1;
          node_wd.sibling = nfc;
          node_wd.color   = node_rd.color;
        end else begin
          cur_next = node_rd.sibling[AW-1:0];
          node_ra  = node_rd.sibling[AW-1:0];
        end
      end
      glzw_pkg::ST_EMIT: begin
        put_en          = 1'b1;
        child_we        = 1'b1;
        child_wa        = nfc[AW-1:0];
        child_wd        = glzw_pkg::NO_LINK;
        node_we         = 1'b1;
        node_wa         = nfc[AW-1:0];
        node_wd.sibling = glzw_pkg::NO_LINK;
        node_wd.color   = pix;
        prefix_next     = AW'(pix);
        if (!(grow && code_width >= glzw_pkg::MAX_CODE_BITS)) begin
          nfc_next = nfc + LW'(1);
          if (grow) code_width_next = code_width + SW'(1);
        end
      end
      glzw_pkg::ST_CLEAR: begin
        // clear code at full width, then restart the code space
        put_en          = 1'b1;
        put_val         = AW'(colors);
        clear_roots     = 1'b1;
        nfc_next        = LW'(colors) + LW'(2);
        code_width_next = size_now + SW'(1);
      end
      glzw_pkg::ST_FIN_END: begin
        put_en  = 1'b1;
        put_val = AW'(colors) + AW'(1);
      end
      glzw_pkg::ST_DRAIN: begin
        if (out_fire) begin
          bit_buf_next   = bit_buf >> 8;
          bit_count_next = (bit_count >= NW'(8)) ? bit_count - NW'(8) : '0;
        end else if (!have_byte && flush_all) begin
          do_init = 1'b1;
        end
      end
      default: ;
    endcase

    if (put_en) begin
      bit_buf_next   = bit_buf | (BW'(put_val) << bit_count);
      bit_count_next = bit_count + NW'(code_width);
    end

    if (child_we && (child_wa[AW-1:RW] == '0)) begin
      root_valid_next[child_wa[RW-1:0]] = 1'b1;
    end

    if (clear_roots) root_valid_next = '0;

    if (do_init) begin
      size_now_next   = init_size;
      code_width_next = init_size + SW'(1);
      nfc_next        = LW'(init_colors) + LW'(2);
      bit_buf_next    = BW'(init_colors);
      bit_count_next  = NW'(init_size) + NW'(1);
      prefix_next     = '0;
      awaiting_next   = 1'b1;
      flush_all_next  = 1'b0;
      root_valid_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_code_size <= glzw_pkg::MIN_SIZE_RESET;
    end else if (cfg_we) begin
      min_code_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= glzw_pkg::ST_IDLE;
      size_now   <= glzw_pkg::MIN_SIZE_RESET;
      code_width <= glzw_pkg::MIN_SIZE_RESET + SW'(1);
      nfc        <= LW'(glzw_pkg::colors_of(glzw_pkg::MIN_SIZE_RESET)) + LW'(2);
      bit_buf    <= BW'(glzw_pkg::colors_of(glzw_pkg::MIN_SIZE_RESET));
      bit_count  <= NW'(glzw_pkg::MIN_SIZE_RESET) + NW'(1);
      prefix     <= '0;
      awaiting   <= 1'b1;
      flush_all  <= 1'b0;
      root_valid <= '0;
    end else begin
      state      <= state_next;
      size_now   <= size_now_next;
      code_width <= code_width_next;
      nfc        <= nfc_next;
      bit_buf    <= bit_buf_next;
      bit_count  <= bit_count_next;
      prefix     <= prefix_next;
      awaiting   <= awaiting_next;
      flush_all  <= flush_all_next;
      root_valid <= root_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pix         <= pix_next;
    cur         <= cur_next;
    root_nolink <= (child_ra[AW-1:RW] == '0) && !root_valid[child_ra[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (child_we) child_mem[child_wa] <= child_wd;
    child_rd <= child_mem[child_ra];
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_rd <= node_mem[node_ra];
  end

  // the packed codes always fit in the bit buffer
  a_count_fits: assert property (@(posedge clk) disable iff (rst)
    bit_count <= NW'(BW - 1))
    else $error("bit buffer overflow");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    code_width >= SW'(3) && code_width <= glzw_pkg::MAX_CODE_BITS)
    else $error("code width out of range");

  a_nfc_range: assert property (@(posedge clk) disable iff (rst)
    nfc <= glzw_pkg::LAST_FREE_CODE)
    else $error("next free code past table limit");

  // final byte of a finish leaves nothing behind
  a_end_empties: assert property (@(posedge clk) disable iff (rst)
    out_fire && out_ch.end_of_stream |=> bit_count == '0)
    else $error("bits left after end of stream");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.end_of_stream |-> out_ch.last_of_run)
    else $error("end of stream without last of run");

endmodule

`default_nettype wire
